// ===== rtl/record_slot_store_assert.svh =====
// assertion macros for the record slot store
// used by the top level; expects clk and rst_n in scope
`ifndef RECORD_SLOT_STORE_ASSERT_SVH
`define RECORD_SLOT_STORE_ASSERT_SVH

// invariant that must hold at every clock edge out of reset
`define RSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rss_pkg.sv =====
// shared constants, codes and types of the record slot store
// no dependencies; imported by rss_slot_find and record_slot_store
package rss_pkg;

    // table geometry
    localparam int SLOTS       = 32;
    localparam int RECORD_BITS = 32;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);

    // stream field widths
    localparam int ACTION_W   = 3;
    localparam int INDEX_W    = 5;
    localparam int RECIN_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int RECOUT_W   = 32;
    localparam int COUNT_W    = 6;
    localparam int STORE_BITS = (RECORD_BITS < RECIN_W) ? RECORD_BITS : RECIN_W;
    localparam int S_DATA_W   = ((ACTION_W + INDEX_W + RECIN_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((STATUS_W + RECOUT_W + COUNT_W + 7) / 8) * 8;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ADD       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_GET       = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DEL_INDEX = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEL_FIRST = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DEL_LAST  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DEL_ALL   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd3;

    // slot search results over the in-use marks
    typedef struct packed {
        logic             has_free;
        logic [IDX_W-1:0] free_idx;
        logic             has_used;
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] last_idx;
    } slot_find_t;

endpackage

// ===== rtl/rss_slot_find.sv =====
// priority search over the in-use marks: lowest free, lowest used, highest used
// depends on rss_pkg
module rss_slot_find (
    input  logic [rss_pkg::SLOTS-1:0] used,
    output rss_pkg::slot_find_t       find
);
    import rss_pkg::*;

    // lowest free and lowest used: scan downward so the lowest hit wins
    // highest used: scan upward so the highest hit wins
    always_comb
    begin
        find = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                find.has_free = 1'b1;
                find.free_idx = IDX_W'(i);
            end
            if (used[i])
            begin
                find.has_used  = 1'b1;
                find.first_idx = IDX_W'(i);
            end
        end
        for (int j = 0; j < SLOTS; j++)
        begin
            if (used[j])
            begin
                find.last_idx = IDX_W'(j);
            end
        end
    end

endmodule

// ===== rtl/record_slot_store.sv =====
// top level of the record slot store: stream ports, record memory, in-use marks
// depends on rss_pkg, rss_slot_find and record_slot_store_assert.svh
//
// A table of SLOTS record slots with an in-use mark each and a record count.
// Every item on the input stream is one operation (add, get, delete at index,
// delete first, delete last, delete all) and yields exactly one result item
// with status, the record read by get (zero otherwise) and the count after the
// operation. The cycle of acceptance issues the read of the record memory into a
// register; in the execute state, once the output register is free, the block
// decides, updates marks, count and memory, and loads the output register. It
// returns to idle and can take a new item in the cycle after that, also while the
// last result still waits in the output register. Reads of slots never written
// return whatever the memory holds. No clearing pass is needed after reset.
`include "record_slot_store_assert.svh"

module record_slot_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rss_pkg::S_DATA_W-1:0] s_tdata,  // action, slot_index, record_in
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rss_pkg::M_DATA_W-1:0] m_tdata   // status, record_out, record_count
);
    import rss_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;
    localparam int   CMP_W  = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

    logic                  state_reg, state_next;
    logic [SLOTS-1:0]      used_reg, used_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ACTION_W-1:0]   action_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [STORE_BITS-1:0] record_reg;
    logic [STORE_BITS-1:0] rd_data_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [RECOUT_W-1:0]   rec_out_reg, rec_out_next;
    logic [CNT_W-1:0]      cnt_out_reg;

    logic [STORE_BITS-1:0] mem [SLOTS];

    logic                  s_accept;
    logic                  exec_done;
    logic                  idx_ok;
    logic                  wr_en;
    logic [IDX_W-1:0]      slot_addr;
    logic [CNT_W-1:0]      count_drop;
    slot_find_t            find;

    // input field split
    logic [ACTION_W-1:0] in_action;
    logic [INDEX_W-1:0]  in_index;
    logic [RECIN_W-1:0]  in_record;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_index  = s_tdata[ACTION_W+INDEX_W-1:ACTION_W];
    assign in_record = s_tdata[ACTION_W+INDEX_W+RECIN_W-1:ACTION_W+INDEX_W];

    // handshakes
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign exec_done = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    // slot search over the in-use marks
    rss_slot_find u_find (
        .used (used_reg),
        .find (find)
    );

    // record memory: read at acceptance, written at the end of an add
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            rd_data_reg <= mem[IDX_W'(in_index)];
        end
        if (wr_en)
        begin
            mem[find.free_idx] <= record_reg;
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            action_reg <= in_action;
            index_reg  <= in_index;
            record_reg <= in_record[STORE_BITS-1:0];
        end
    end

    // index check against count and table size
    assign idx_ok     = (CMP_W'(index_reg) < CMP_W'(count_reg)) &&
                        (CMP_W'(index_reg) < CMP_W'(SLOTS));
    assign slot_addr  = IDX_W'(index_reg);
    assign count_drop = (count_reg != '0) ? count_reg - CNT_W'(1) : count_reg;

    // operation decode and state update
    always_comb
    begin
        used_next    = used_reg;
        count_next   = count_reg;
        status_next  = STS_OK;
        rec_out_next = '0;
        wr_en        = 1'b0;
        unique case (action_reg)
            ACT_ADD:
            begin
                if ((count_reg < CNT_W'(SLOTS)) && find.has_free)
                begin
                    used_next[find.free_idx] = 1'b1;
                    count_next               = count_reg + CNT_W'(1);
                    wr_en                    = exec_done;
                end
                else
                begin
                    status_next = STS_FULL;
                end
            end
            ACT_GET:
            begin
                if (idx_ok)
                begin
                    rec_out_next = RECOUT_W'(rd_data_reg);
                end
                else
                begin
                    status_next = STS_BAD_INDEX;
                end
            end
            ACT_DEL_INDEX:
            begin
                if (idx_ok)
                begin
                    used_next[slot_addr] = 1'b0;
                    count_next           = count_drop;
                end
                else
                begin
                    status_next = STS_BAD_INDEX;
                end
            end
            ACT_DEL_FIRST:
            begin
                if (find.has_used)
                begin
                    used_next[find.first_idx] = 1'b0;
                    count_next                = count_drop;
                end
                else
                begin
                    status_next = STS_EMPTY;
                end
            end
            ACT_DEL_LAST:
            begin
                if (find.has_used)
                begin
                    used_next[find.last_idx] = 1'b0;
                    count_next               = count_drop;
                end
                else
                begin
                    status_next = STS_EMPTY;
                end
            end
            ACT_DEL_ALL:
            begin
                used_next  = '0;
                count_next = '0;
            end
            default:
            begin
                // unknown actions leave everything as is
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        if (s_accept)
        begin
            state_next = S_EXEC;
        end
        else if (exec_done)
        begin
            state_next = S_IDLE;
        end
    end

    // output register valid
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (exec_done)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (exec_done)
            begin
                used_reg  <= used_next;
                count_reg <= count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (exec_done)
        begin
            status_reg  <= status_next;
            rec_out_reg <= rec_out_next;
            cnt_out_reg <= count_next;
        end
    end

    // output packing
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({COUNT_W'(cnt_out_reg), rec_out_reg, status_reg});

    // checks
    `RSS_ASSERT(a_count_range, count_reg <= CNT_W'(SLOTS), "record count beyond table size")
    `RSS_ASSERT(a_count_marks, 32'(count_reg) <= 32'($countones(used_reg)), "count above used marks")
    `RSS_ASSERT_NEXT(a_del_all, exec_done && (action_reg == ACT_DEL_ALL), (count_reg == '0) && (used_reg == '0), "delete all left state")

endmodule
